[src/aot_pkg.sv]
// ----------------------------------------------------------------------------
// aot_pkg
// Shared types and codes for the active order table.
// ----------------------------------------------------------------------------
package aot_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 4096;
  localparam int unsigned PROBE_LIMIT_DEF   = 8;
  localparam int unsigned STEP_W            = 7;

  localparam logic [63:0] HASH_MULT = 64'h9E3779B97F4A7C15;

  localparam logic [7:0] CHAR_BUY  = 8'd66;
  localparam logic [7:0] CHAR_SELL = 8'd83;

  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_REDUCE  = 3'd1;
  localparam logic [2:0] OP_DELETE  = 3'd2;
  localparam logic [2:0] OP_REPLACE = 3'd3;
  localparam logic [2:0] OP_LOOKUP  = 3'd4;

  localparam logic [2:0] STS_OK       = 3'd0;
  localparam logic [2:0] STS_BAD_SIDE = 3'd1;
  localparam logic [2:0] STS_DUP      = 3'd2;
  localparam logic [2:0] STS_UNKNOWN  = 3'd3;
  localparam logic [2:0] STS_LOCATE   = 3'd4;
  localparam logic [2:0] STS_EXCESS   = 3'd5;
  localparam logic [2:0] STS_REP_ACT  = 3'd6;
  localparam logic [2:0] STS_FULL     = 3'd7;

  typedef struct packed {
    logic        valid;
    logic [63:0] key;
    logic [15:0] locate;
    logic        side;
    logic [31:0] remaining;
    logic [63:0] symbol;
    logic [31:0] price;
  } aot_rec_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_MOD,
    ST_PROBE,
    ST_DECIDE,
    ST_WR2,
    ST_RESP
  } aot_state_t;

endpackage

[src/active_order_table.sv]
// ----------------------------------------------------------------------------
// active_order_table
// Hashed table of active orders with add, reduce, delete, replace, lookup.
// ----------------------------------------------------------------------------
// One item at a time. An item takes a hash multiply on one shared 32x32
// multiplier, a home-slot reduction (a mask when TABLE_ENTRIES is a power of
// two, a bit-serial remainder otherwise), probing of the slot memory, a
// decide/write state and a result state; the next item is taken in the idle
// state after the result is loaded. Replace hashes, probes and decides a
// second key and adds a second write state. After reset the slot memory is
// cleared one slot a cycle, every slot, with in_stall held high. A result
// waits in the output register while the next item is taken.
module active_order_table #(
  parameter int unsigned TABLE_ENTRIES = aot_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned PROBE_LIMIT   = aot_pkg::PROBE_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [63:0] in_order_ref,
  input  logic [63:0] in_replacement_ref,
  input  logic [15:0] in_locate_code,
  input  logic [7:0]  in_side_byte,
  input  logic [31:0] in_share_count,
  input  logic [63:0] in_symbol,
  input  logic [31:0] in_price,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic        out_hit,
  output logic [63:0] out_entry_ref,
  output logic [15:0] out_entry_locate,
  output logic        out_entry_side,
  output logic [31:0] out_entry_shares,
  output logic [63:0] out_entry_symbol,
  output logic [31:0] out_entry_price,
  output logic [12:0] out_active_count
);

  localparam int unsigned IDXW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW   = $clog2(TABLE_ENTRIES + 1);
  localparam bit          POW2 = ((1 << IDXW) == TABLE_ENTRIES);

  aot_pkg::aot_state_t state_r, state_nxt;

  aot_pkg::aot_rec_t mem [TABLE_ENTRIES];
  aot_pkg::aot_rec_t rd_r, hit_rec_r, wd;
  logic              we;
  logic [IDXW-1:0]   wa;

  logic [2:0]  op_r;
  logic [63:0] ref_r, rep_r, sym_r;
  logic [15:0] loc_r;
  logic [7:0]  side_r;
  logic [31:0] shares_r, price_r;

  logic                      pass_r;
  logic [aot_pkg::STEP_W-1:0] step_r;
  logic [31:0]               acc_r;
  logic [IDXW-1:0]           rem_r, addr_r, ev_addr_r, hit_addr_r, free_addr_r;
  logic                      rv_r, hit_r, rep_hit_r, free_r;
  logic [CW-1:0]             cnt_r;

  logic [2:0] res_status_r;
  logic       res_hit_r;

  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic        out_hit_r;
  aot_pkg::aot_rec_t out_rec_r;
  logic [12:0] out_cnt_r;

  logic [63:0] cur_key;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [IDXW:0] shifted, rem_nxt;
  logic [IDXW-1:0] addr_inc;
  logic        match, free_cand, last_probe, mod_done, out_load;
  logic [2:0]  dec_status;
  logic        dec_hit, go_pass1, need_wr2, cnt_inc, cnt_dec;
  logic [31:0] new_rem;

  assign cur_key  = pass_r ? rep_r : ref_r;
  assign addr_inc = (addr_r == IDXW'(TABLE_ENTRIES - 1)) ? '0 : addr_r + 1'b1;

  always_comb begin
    unique case (step_r[1:0])
      2'd0:    begin mul_a = cur_key[31:0];  mul_b = aot_pkg::HASH_MULT[31:0];  end
      2'd1:    begin mul_a = cur_key[63:32]; mul_b = aot_pkg::HASH_MULT[31:0];  end
      default: begin mul_a = cur_key[31:0];  mul_b = aot_pkg::HASH_MULT[63:32]; end
    endcase
  end
  assign prod = mul_a * mul_b;

  assign shifted = {rem_r, acc_r[31]};
  assign rem_nxt = (shifted >= (IDXW+1)'(TABLE_ENTRIES)) ?
                   shifted - (IDXW+1)'(TABLE_ENTRIES) : shifted;
  assign mod_done = POW2 || (step_r == aot_pkg::STEP_W'(31));

  assign match      = rv_r && rd_r.valid && (rd_r.key == cur_key);
  assign free_cand  = rv_r && (!rd_r.valid || (pass_r && ev_addr_r == hit_addr_r));
  assign last_probe = (step_r == aot_pkg::STEP_W'(PROBE_LIMIT));
  assign new_rem    = hit_rec_r.remaining - shares_r;

  assign out_load = (state_r == aot_pkg::ST_RESP) && (!out_valid_r || !out_stall);

  // decision
  always_comb begin
    dec_status = aot_pkg::STS_OK;
    dec_hit    = 1'b0;
    go_pass1   = 1'b0;
    need_wr2   = 1'b0;
    cnt_inc    = 1'b0;
    cnt_dec    = 1'b0;
    we         = 1'b0;
    wa         = hit_addr_r;
    wd         = hit_rec_r;
    if (state_r == aot_pkg::ST_CLEAR) begin
      we = 1'b1;
      wa = addr_r;
      wd = '0;
    end else if (state_r == aot_pkg::ST_WR2) begin
      we = 1'b1;
      wa = free_addr_r;
      wd = '{valid: 1'b1, key: rep_r, locate: hit_rec_r.locate, side: hit_rec_r.side,
             remaining: shares_r, symbol: hit_rec_r.symbol, price: price_r};
    end else if (state_r == aot_pkg::ST_DECIDE) begin
      case (op_r)
        aot_pkg::OP_ADD: begin
          if (side_r != aot_pkg::CHAR_BUY && side_r != aot_pkg::CHAR_SELL) begin
            dec_status = aot_pkg::STS_BAD_SIDE;
          end else if (hit_r) begin
            dec_status = aot_pkg::STS_DUP;
          end else if (!free_r) begin
            dec_status = aot_pkg::STS_FULL;
          end else begin
            we      = 1'b1;
            wa      = free_addr_r;
            wd      = '{valid: 1'b1, key: ref_r, locate: loc_r,
                        side: (side_r == aot_pkg::CHAR_SELL), remaining: shares_r,
                        symbol: sym_r, price: price_r};
            cnt_inc = 1'b1;
          end
        end
        aot_pkg::OP_LOOKUP: begin
          if (hit_r) dec_hit = 1'b1;
          else       dec_status = aot_pkg::STS_UNKNOWN;
        end
        aot_pkg::OP_REDUCE, aot_pkg::OP_DELETE, aot_pkg::OP_REPLACE: begin
          if (!hit_r) begin
            dec_status = aot_pkg::STS_UNKNOWN;
          end else if (hit_rec_r.locate != loc_r) begin
            dec_status = aot_pkg::STS_LOCATE;
          end else if (op_r == aot_pkg::OP_REDUCE) begin
            if (shares_r > hit_rec_r.remaining) begin
              dec_status = aot_pkg::STS_EXCESS;
            end else begin
              dec_hit      = 1'b1;
              we           = 1'b1;
              wd.remaining = new_rem;
              wd.valid     = (new_rem != '0);
              cnt_dec      = (new_rem == '0);
            end
          end else if (op_r == aot_pkg::OP_DELETE) begin
            dec_hit  = 1'b1;
            we       = 1'b1;
            wd.valid = 1'b0;
            cnt_dec  = 1'b1;
          end else if (!pass_r) begin
            go_pass1 = 1'b1;
          end else if (rep_hit_r) begin
            dec_status = aot_pkg::STS_REP_ACT;
          end else if (!free_r) begin
            dec_status = aot_pkg::STS_FULL;
          end else begin
            dec_hit  = 1'b1;
            we       = 1'b1;
            wd.valid = 1'b0;
            need_wr2 = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      aot_pkg::ST_CLEAR:  if (addr_r == IDXW'(TABLE_ENTRIES - 1)) state_nxt = aot_pkg::ST_IDLE;
      aot_pkg::ST_IDLE:   if (in_valid) state_nxt = aot_pkg::ST_MUL;
      aot_pkg::ST_MUL:    if (step_r == aot_pkg::STEP_W'(2)) state_nxt = aot_pkg::ST_MOD;
      aot_pkg::ST_MOD:    if (mod_done) state_nxt = aot_pkg::ST_PROBE;
      aot_pkg::ST_PROBE:  if (last_probe) state_nxt = aot_pkg::ST_DECIDE;
      aot_pkg::ST_DECIDE: begin
        if (go_pass1)      state_nxt = aot_pkg::ST_MUL;
        else if (need_wr2) state_nxt = aot_pkg::ST_WR2;
        else               state_nxt = aot_pkg::ST_RESP;
      end
      aot_pkg::ST_WR2:    state_nxt = aot_pkg::ST_RESP;
      aot_pkg::ST_RESP:   if (out_load) state_nxt = aot_pkg::ST_IDLE;
      default:            state_nxt = aot_pkg::ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    in_stall = (state_r != aot_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aot_pkg::ST_CLEAR;
      addr_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      rv_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rv_r    <= (state_r == aot_pkg::ST_PROBE) && !last_probe;

      if (state_r == aot_pkg::ST_CLEAR || (state_r == aot_pkg::ST_PROBE && !last_probe))
        addr_r <= addr_inc;
      else if (state_r == aot_pkg::ST_MOD && mod_done)
        addr_r <= POW2 ? acc_r[IDXW-1:0] : rem_nxt[IDXW-1:0];

      if (cnt_inc)      cnt_r <= cnt_r + 1'b1;
      else if (cnt_dec) cnt_r <= cnt_r - 1'b1;

      if (out_load)        out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    ev_addr_r <= addr_r;

    if (state_r == aot_pkg::ST_IDLE && in_valid) begin
      op_r      <= in_opcode;
      ref_r     <= in_order_ref;
      rep_r     <= in_replacement_ref;
      loc_r     <= in_locate_code;
      side_r    <= in_side_byte;
      shares_r  <= in_share_count;
      sym_r     <= in_symbol;
      price_r   <= in_price;
      pass_r    <= 1'b0;
      hit_r     <= 1'b0;
      rep_hit_r <= 1'b0;
      free_r    <= 1'b0;
      step_r    <= '0;
    end else if (state_r == aot_pkg::ST_MUL) begin
      acc_r  <= (step_r == '0) ? prod[63:32] : acc_r + prod[31:0];
      step_r <= (step_r == aot_pkg::STEP_W'(2)) ? '0 : step_r + 1'b1;
      rem_r  <= '0;
    end else if (state_r == aot_pkg::ST_MOD) begin
      rem_r  <= rem_nxt[IDXW-1:0];
      acc_r  <= acc_r << 1;
      step_r <= mod_done ? '0 : step_r + 1'b1;
    end else if (state_r == aot_pkg::ST_PROBE) begin
      step_r <= step_r + 1'b1;
      if (!pass_r && match && !hit_r) begin
        hit_r      <= 1'b1;
        hit_addr_r <= ev_addr_r;
        hit_rec_r  <= rd_r;
      end
      if (pass_r && match) rep_hit_r <= 1'b1;
      if (free_cand && !free_r) begin
        free_r      <= 1'b1;
        free_addr_r <= ev_addr_r;
      end
    end else if (state_r == aot_pkg::ST_DECIDE) begin
      step_r       <= '0;
      res_status_r <= dec_status;
      res_hit_r    <= dec_hit;
      if (go_pass1) begin
        pass_r <= 1'b1;
        free_r <= 1'b0;
      end
    end

    if (out_load) begin
      out_status_r <= res_status_r;
      out_hit_r    <= res_hit_r;
      out_rec_r    <= res_hit_r ? hit_rec_r : '0;
      out_cnt_r    <= 13'(cnt_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_hit          = out_hit_r;
  assign out_entry_ref    = out_rec_r.key;
  assign out_entry_locate = out_rec_r.locate;
  assign out_entry_side   = out_rec_r.side;
  assign out_entry_shares = out_rec_r.remaining;
  assign out_entry_symbol = out_rec_r.symbol;
  assign out_entry_price  = out_rec_r.price;
  assign out_active_count = out_cnt_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(TABLE_ENTRIES)) else $error("active count beyond table size");

  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == aot_pkg::ST_CLEAR |-> in_stall) else $error("item taken during clear");

  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_status == aot_pkg::STS_OK)
    else $error("entry reported with error status");

endmodule
